FILE: hw/rtl/iprf_pkg.sv
package iprf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_MATCH = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic        bad_len;
        logic [31:0] address;
        logic [31:0] first;
        logic [31:0] last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic       matched;
    } res_t;

endpackage

FILE: hw/rtl/ipv4_prefix_range_filter_unit.sv
// keeps up to 64 disjoint ipv4 ranges built from cidr prefixes. each request
// (tdata: req_type, address, prefix_len) yields one result (tdata: status,
// matched). a request reads every table slot once from a ram, one slot a cycle.
// a match or a covered add is answered once the scan drains, a stored add or a
// full table after a further write state; an add with a bad prefix length skips
// the scan. a two-entry queue takes new requests while one is worked on, and a
// result waiting on m_axis_tready does not hold up the next request's scan.
module ipv4_prefix_range_filter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // req_type, address, prefix_len, pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // status, matched, pad
);

    logic           q_valid, q_ready;
    iprf_pkg::cmd_t q_cmd;
    iprf_pkg::res_t r_res;

    iprf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    iprf_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .r_valid (m_axis_tvalid),
        .r_ready (m_axis_tready),
        .r_res   (r_res)
    );

    assign m_axis_tdata = {5'd0, r_res.matched, r_res.status};

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] <= iprf_pkg::ST_FULL) else $error("bad status");
    a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == iprf_pkg::ST_OK)
        else $error("match with error status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");

endmodule

FILE: hw/rtl/iprf_ram.sv
module iprf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/iprf_front.sv
module iprf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,
    output logic                 q_valid,
    input  logic                 q_ready,
    output iprf_pkg::cmd_t       q_cmd
);

    // two-entry queue towards the table engine
    iprf_pkg::cmd_t buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_ptr;

    iprf_pkg::cmd_t cmd_in;
    logic [5:0]  len;
    logic [31:0] mask;

    always_comb
    begin
        len = s_tdata[38:33];
        if (len == 6'd0)
            mask = 32'd0;
        else
            mask = 32'hffffffff << (6'd32 - len);
        cmd_in.req_type = s_tdata[0];
        cmd_in.address  = s_tdata[32:1];
        cmd_in.bad_len  = (len > 6'd32);
        cmd_in.first    = s_tdata[32:1] & mask;
        cmd_in.last     = (s_tdata[32:1] & mask) | ~mask;
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = buf_reg[rd_reg];
    assign wr_ptr   = rd_reg ^ cnt_reg[0];

    always_comb
    begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (s_tvalid && s_tready)
            cnt_next = cnt_next + 2'd1;
        if (q_valid && q_ready)
        begin
            cnt_next = cnt_next - 2'd1;
            rd_next  = ~rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            buf_reg[wr_ptr] <= cmd_in;
        end
    end

endmodule

FILE: hw/rtl/iprf_engine.sv
module iprf_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  iprf_pkg::cmd_t q_cmd,
    output logic           r_valid,
    input  logic           r_ready,
    output iprf_pkg::res_t r_res
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    localparam int IW = iprf_pkg::IDX_W;
    localparam int CW = iprf_pkg::CNT_W;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pv_reg, pv_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic          hit_reg, hit_next;
    logic          cover_reg, cover_next;
    logic          free_reg;
    logic [IW-1:0] slot_reg;
    logic [iprf_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [iprf_pkg::TABLE_DEPTH-1:0] kill_reg;
    iprf_pkg::cmd_t cmd_reg;
    iprf_pkg::res_t res_reg, res_next;
    iprf_pkg::res_t out_reg;
    logic           rv_reg, rv_next;

    logic [63:0] rd_data;
    logic        wr_en;
    logic [63:0] wr_data;
    logic [31:0] e_start, e_end;
    logic        e_valid;
    logic        nest_now;

    logic [iprf_pkg::TABLE_DEPTH-1:0] drain_valid;
    logic [IW-1:0] d_slot;
    logic          d_free;

    iprf_ram #(.WIDTH(64), .DEPTH(iprf_pkg::TABLE_DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data),
        .rd_addr (idx_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    assign wr_en    = (state_reg == S_WRITE) && free_reg;
    assign wr_data  = {cmd_reg.first, cmd_reg.last};
    assign e_start  = rd_data[63:32];
    assign e_end    = rd_data[31:0];
    assign e_valid  = pv_reg && valid_reg[pidx_reg];
    assign nest_now = e_valid && e_start >= cmd_reg.first && e_end <= cmd_reg.last;
    assign q_ready  = (state_reg == S_IDLE);
    assign r_valid  = rv_reg;
    assign r_res    = out_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pv_next    = 1'b0;
        pidx_next  = idx_reg[IW-1:0];
        hit_next   = hit_reg;
        cover_next = cover_reg;
        res_next   = res_reg;
        rv_next    = rv_reg;
        if (rv_reg && r_ready)
            rv_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    cover_next = 1'b0;
                    if (q_cmd.req_type == iprf_pkg::REQ_ADD && q_cmd.bad_len)
                    begin
                        res_next   = '{status: iprf_pkg::ST_BAD_LEN, matched: 1'b0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN, S_DRAIN:
            begin
                if (state_reg == S_SCAN)
                begin
                    pv_next  = 1'b1;
                    idx_next = idx_reg + CW'(1);
                    if (idx_reg == CW'(iprf_pkg::TABLE_DEPTH - 1))
                        state_next = S_DRAIN;
                end
                if (e_valid)
                begin
                    if (e_start <= cmd_reg.address && cmd_reg.address <= e_end)
                        hit_next = 1'b1;
                    if (e_start <= cmd_reg.first && e_end >= cmd_reg.last)
                        cover_next = 1'b1;
                end
                if (state_reg == S_DRAIN)
                begin
                    if (cmd_reg.req_type == iprf_pkg::REQ_MATCH)
                    begin
                        res_next   = '{status: iprf_pkg::ST_OK, matched: hit_next};
                        state_next = S_DONE;
                    end
                    else if (cover_next)
                    begin
                        res_next   = '{status: iprf_pkg::ST_OK, matched: 1'b0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                // store into the lowest free slot found at the end of the scan
                if (free_reg)
                    res_next = '{status: iprf_pkg::ST_OK, matched: 1'b0};
                else
                    res_next = '{status: iprf_pkg::ST_FULL, matched: 1'b0};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rv_reg || r_ready)
                begin
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        drain_valid = valid_reg & ~kill_reg;
        if (nest_now)
            drain_valid[pidx_reg] = 1'b0;
        d_slot = '0;
        d_free = 1'b0;
        for (int i = iprf_pkg::TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!drain_valid[i])
            begin
                d_slot = IW'(i);
                d_free = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            pv_reg    <= 1'b0;
            rv_reg    <= 1'b0;
            valid_reg <= '0;
            kill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pv_reg    <= pv_next;
            rv_reg    <= rv_next;
            if (state_reg == S_IDLE)
                kill_reg <= '0;
            else if ((state_reg == S_SCAN || state_reg == S_DRAIN) && nest_now)
                kill_reg[pidx_reg] <= 1'b1;
            if (state_reg == S_DRAIN && cmd_reg.req_type == iprf_pkg::REQ_ADD
                && !cover_next)
                valid_reg <= drain_valid;
            else if (state_reg == S_WRITE && free_reg)
                valid_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg  <= pidx_next;
        hit_reg   <= hit_next;
        cover_reg <= cover_next;
        res_reg   <= res_next;
        if (state_reg == S_IDLE && q_valid && q_ready)
            cmd_reg <= q_cmd;
        if (state_reg == S_DRAIN)
        begin
            free_reg <= d_free;
            slot_reg <= d_slot;
        end
        if (state_reg == S_DONE && (!rv_reg || r_ready))
            out_reg <= res_reg;
    end

endmodule

FILE: verif/iprf_checker.sv
`timescale 1ns / 100ps

module iprf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    output int          fail_count,
    output int          pending
);

    logic [31:0]    span_first [iprf_pkg::TABLE_DEPTH];
    logic [31:0]    span_last [iprf_pkg::TABLE_DEPTH];
    logic           span_used [iprf_pkg::TABLE_DEPTH];
    iprf_pkg::res_t expected_results[$];

    task automatic report(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic iprf_pkg::res_t filter_predict(input logic req,
                                                      input logic [31:0] addr,
                                                      input logic [5:0] len);
        iprf_pkg::res_t r;
        logic [31:0] mask;
        logic [31:0] lo;
        logic [31:0] hi;
        int slot;
        r = '0;
        if (req == iprf_pkg::REQ_MATCH)
        begin
            for (int i = 0; i < iprf_pkg::TABLE_DEPTH; i++)
                if (span_used[i] && span_first[i] <= addr && addr <= span_last[i])
                    r.matched = 1'b1;
            return r;
        end
        if (len > 6'd32)
        begin
            r.status = iprf_pkg::ST_BAD_LEN;
            return r;
        end
        mask = (len == 0) ? 32'd0 : (32'hffffffff << (32 - len));
        lo = addr & mask;
        hi = lo | ~mask;
        for (int i = 0; i < iprf_pkg::TABLE_DEPTH; i++)
            if (span_used[i] && span_first[i] <= lo && span_last[i] >= hi)
                return r;
        for (int i = 0; i < iprf_pkg::TABLE_DEPTH; i++)
            if (span_used[i] && span_first[i] >= lo && span_last[i] <= hi)
                span_used[i] = 1'b0;
        slot = -1;
        for (int i = iprf_pkg::TABLE_DEPTH - 1; i >= 0; i--)
            if (!span_used[i])
                slot = i;
        if (slot < 0)
        begin
            r.status = iprf_pkg::ST_FULL;
            return r;
        end
        span_first[slot] = lo;
        span_last[slot] = hi;
        span_used[slot] = 1'b1;
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
        for (int i = 0; i < iprf_pkg::TABLE_DEPTH; i++)
            span_used[i] = 1'b0;
    end

    always @(posedge clk)
    begin
        iprf_pkg::res_t got;
        iprf_pkg::res_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(filter_predict(s_axis_tdata[0],
                    s_axis_tdata[32:1], s_axis_tdata[38:33]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tdata[1:0];
                got.matched = m_axis_tdata[2];
                if (expected_results.size() == 0)
                    report("result with no request outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report($sformatf("status %0d, expected %0d",
                                         got.status, want.status));
                    if (got.matched !== want.matched)
                        report($sformatf("matched %0d, expected %0d",
                                         got.matched, want.matched));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    int          fail_count;
    int          pending;
    int          cycle_count;

    ipv4_prefix_range_filter_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    iprf_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 40)
            return 0;
        if (p < 90)
            return $urandom_range(3, 1);
        return $urandom_range(150, 20);
    endfunction

    // a few base addresses so adds nest and matches hit
    logic [31:0] base_pool [8];

    task automatic send_request(input logic req, input logic [31:0] addr,
                                input logic [5:0] len);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, len, addr, req};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic        req;
        logic [31:0] addr;
        logic [5:0]  len;
        int p;
        req = 1'($urandom_range(1));
        p = $urandom_range(99);
        addr = $urandom();
        if (p < 70)
            addr = base_pool[$urandom_range(7)] ^ ($urandom() >> $urandom_range(31, 8));
        p = $urandom_range(99);
        if (p < 85)
            len = 6'($urandom_range(32, 4));
        else if (p < 92)
            len = 6'($urandom_range(3));
        else
            len = 6'($urandom_range(63, 33));
        send_request(req, addr, len);
    endtask

    initial
    begin
        int stall;
        cycle_count = 0;
        stall = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 2000000)
            begin
                $display("tb: FAIL");
                $finish;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        for (int i = 0; i < 8; i++)
            base_pool[i] = $urandom();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, bad length, nesting, coverage
        send_request(iprf_pkg::REQ_MATCH, 32'h0, 6'd0);
        send_request(iprf_pkg::REQ_MATCH, 32'hffffffff, 6'd63);
        send_request(iprf_pkg::REQ_ADD, 32'hffffffff, 6'd63);
        send_request(iprf_pkg::REQ_ADD, 32'h12345678, 6'd33);
        send_request(iprf_pkg::REQ_ADD, 32'hc0a80101, 6'd32);
        send_request(iprf_pkg::REQ_MATCH, 32'hc0a80101, 6'd0);
        send_request(iprf_pkg::REQ_MATCH, 32'hc0a80102, 6'd0);
        send_request(iprf_pkg::REQ_ADD, 32'hc0a80155, 6'd24);
        send_request(iprf_pkg::REQ_ADD, 32'hc0a80109, 6'd28);
        send_request(iprf_pkg::REQ_MATCH, 32'hc0a801ff, 6'd0);
        send_request(iprf_pkg::REQ_ADD, 32'h0a000000, 6'd8);
        send_request(iprf_pkg::REQ_ADD, 32'hffffffff, 6'd32);
        send_request(iprf_pkg::REQ_MATCH, 32'hffffffff, 6'd0);
        // fill the table with disjoint /32s in an uncovered region until it is full
        for (int i = 0; i < 70; i++)
            send_request(iprf_pkg::REQ_ADD, 32'h40000000 | (32'(i) << 2), 6'd32);
        send_request(iprf_pkg::REQ_MATCH, 32'h40000008, 6'd40);

        for (int i = 0; i < 520; i++)
        begin
            if (i % 130 == 0)
                for (int k = 0; k < 8; k++)
                    base_pool[k] = $urandom();
            send_random();
        end

        // whole address space last, as nothing can remove it afterwards
        send_request(iprf_pkg::REQ_ADD, 32'h55aa55aa, 6'd0);
        send_request(iprf_pkg::REQ_MATCH, 32'h00000000, 6'd0);
        send_request(iprf_pkg::REQ_ADD, 32'h00000000, 6'd1);
        send_request(iprf_pkg::REQ_MATCH, 32'h7fffffff, 6'd0);
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
